FILE: src/bpc_pkg.sv
package bpc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_GROUP_A = 3'd0;
  localparam logic [2:0] CFG_GROUP_B = 3'd1;
  localparam logic [2:0] CFG_GROUP_C = 3'd2;
  localparam logic [2:0] CFG_GROUP_D = 3'd3;

  localparam int DIV_STAGES = 32;

  // compensation constants
  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] K_SQ       = 32'd3038;
  localparam logic [31:0] K_LIN      = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] K_OFS      = 32'd3791;
  localparam logic [31:0] X3_BIAS    = 32'd32768;
  localparam logic [31:0] B7_SCALE   = 32'd6250;       // 50000 >> 3
  localparam logic [31:0] SIGN_LIMIT = 32'h8000_0000;
  localparam logic [19:0] P_MAX      = 20'hF_FFFF;

  typedef struct packed {
    logic [47:0] a;
    logic [47:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } cal_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [19:0]        pressure_pa;
    logic               calc_error;
  } out_t;

  // sideband carried alongside a division
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic [15:0] temp;
    logic        err;
    logic        flag;
  } side_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

FILE: src/bpc_div.sv
// 32-stage unsigned restoring divider, one quotient bit per stage
module bpc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        num,
  input  logic [31:0]        den,
  input  bpc_pkg::side_t     in_side,
  output logic               out_vld,
  output logic [31:0]        quo,
  output bpc_pkg::side_t     out_side
);

  logic [31:0]    rem      [bpc_pkg::DIV_STAGES];
  logic [31:0]    nq       [bpc_pkg::DIV_STAGES];
  logic [31:0]    dv       [bpc_pkg::DIV_STAGES];
  bpc_pkg::side_t sd       [bpc_pkg::DIV_STAGES];
  logic           vld      [bpc_pkg::DIV_STAGES];
  logic [31:0]    rem_next [bpc_pkg::DIV_STAGES];
  logic [31:0]    nq_next  [bpc_pkg::DIV_STAGES];

  // one shift and conditional subtract per stage
  always_comb begin
    logic [31:0] pr, pn, pd;
    logic [32:0] t;
    for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
      if (k == 0) begin
        pr = '0;
        pn = num;
        pd = den;
      end else begin
        pr = rem[k-1];
        pn = nq[k-1];
        pd = dv[k-1];
      end
      t = {pr, pn[31]};
      if (t >= {1'b0, pd}) begin
        rem_next[k] = 32'(t - {1'b0, pd});
        nq_next[k]  = {pn[30:0], 1'b1};
      end else begin
        rem_next[k] = t[31:0];
        nq_next[k]  = {pn[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) vld[k] <= (k == 0) ? in_vld : vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < bpc_pkg::DIV_STAGES; k++) begin
        rem[k] <= rem_next[k];
        nq[k]  <= nq_next[k];
        dv[k]  <= (k == 0) ? den : dv[k-1];
        sd[k]  <= (k == 0) ? in_side : sd[k-1];
      end
    end
  end

  assign out_vld  = vld[bpc_pkg::DIV_STAGES-1];
  assign quo      = nq[bpc_pkg::DIV_STAGES-1];
  assign out_side = sd[bpc_pkg::DIV_STAGES-1];

endmodule

FILE: src/bpc_mid.sv
// from the temperature quotient to the pressure division operands
module bpc_mid (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bpc_pkg::cal_t      cal,
  input  logic               in_vld,
  input  logic [31:0]        quo,
  input  bpc_pkg::side_t     in_side,
  output logic               out_vld,
  output logic [31:0]        num,
  output logic [31:0]        den,
  output bpc_pkg::side_t     out_side
);

  logic [31:0] ac1, ac2, ac3, ac4, b1, b2;
  logic [4:0]  vld;

  assign ac1 = bpc_pkg::sx16(cal.a[15:0]);
  assign ac2 = bpc_pkg::sx16(cal.a[31:16]);
  assign ac3 = bpc_pkg::sx16(cal.a[47:32]);
  assign ac4 = {16'b0, cal.b[15:0]};
  assign b1  = bpc_pkg::sx16(cal.c[15:0]);
  assign b2  = bpc_pkg::sx16(cal.c[31:16]);

  // stage 1: b5, temperature, b6
  logic [31:0] x2_c, b5_c, t_c;
  logic [15:0] temp_c;
  logic [31:0] s1_b6;
  logic [15:0] s1_temp;
  logic [18:0] s1_up;
  logic        s1_err;

  always_comb begin
    x2_c = in_side.err ? '0 : (in_side.flag ? 32'(-quo) : quo);
    b5_c = in_side.x1 + x2_c;
    t_c  = $unsigned($signed(b5_c + 32'd8) >>> 4);
    if ($signed(t_c) < -32'sd32768)     temp_c = 16'h8000;
    else if ($signed(t_c) > 32'sd32767) temp_c = 16'h7FFF;
    else                                temp_c = t_c[15:0];
  end

  // stage 2: first products of b6
  logic [31:0] s2_sq, s2_m2, s2_m3;
  logic [15:0] s2_temp;
  logic [18:0] s2_up;
  logic        s2_err;

  // stage 3: second-order products
  logic [31:0] s3_mb1, s3_mb2, s3_m2, s3_m3, sq12_c;
  logic [15:0] s3_temp;
  logic [18:0] s3_up;
  logic        s3_err;

  assign sq12_c = $unsigned($signed(s2_sq) >>> 12);

  // stage 4: b3 and x3 of the b4 path
  logic [31:0] x3_c, v_c, b3_c, x3p_c;
  logic [31:0] s4_b3, s4_x3p;
  logic [15:0] s4_temp;
  logic [18:0] s4_up;
  logic        s4_err;

  always_comb begin
    x3_c  = $unsigned($signed(s3_mb2) >>> 11) + $unsigned($signed(s3_m2) >>> 11);
    v_c   = (((ac1 << 2) + x3_c) << 3) + 32'd2;
    // signed divide by four, truncating toward zero
    b3_c  = $unsigned($signed(v_c + (v_c[31] ? 32'd3 : 32'd0)) >>> 2);
    x3p_c = $unsigned($signed($unsigned($signed(s3_m3) >>> 13)
                               + $unsigned($signed(s3_mb1) >>> 16) + 32'd2) >>> 2);
  end

  // stage 5: b4 and b7
  logic [31:0] s5_b4, s5_b7;
  logic [15:0] s5_temp;
  logic        s5_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_b6   <= b5_c - bpc_pkg::B6_OFFSET;
      s1_temp <= temp_c;
      s1_up   <= in_side.up;
      s1_err  <= in_side.err;

      s2_sq   <= s1_b6 * s1_b6;
      s2_m2   <= ac2 * s1_b6;
      s2_m3   <= ac3 * s1_b6;
      s2_temp <= s1_temp;
      s2_up   <= s1_up;
      s2_err  <= s1_err;

      s3_mb1  <= b1 * sq12_c;
      s3_mb2  <= b2 * sq12_c;
      s3_m2   <= s2_m2;
      s3_m3   <= s2_m3;
      s3_temp <= s2_temp;
      s3_up   <= s2_up;
      s3_err  <= s2_err;

      s4_b3   <= b3_c;
      s4_x3p  <= x3p_c;
      s4_temp <= s3_temp;
      s4_up   <= s3_up;
      s4_err  <= s3_err;

      s5_b4   <= (ac4 * (s4_x3p + bpc_pkg::X3_BIAS)) >> 15;
      s5_b7   <= ({13'b0, s4_up} - s4_b3) * bpc_pkg::B7_SCALE;
      s5_temp <= s4_temp;
      s5_err  <= s4_err;
    end
  end

  // pressure division operands, large b7 divided before doubling
  assign out_vld       = vld[4];
  assign den           = s5_b4;
  assign num           = (s5_b7 < bpc_pkg::SIGN_LIMIT) ? (s5_b7 << 1) : s5_b7;
  assign out_side.x1   = '0;
  assign out_side.up   = '0;
  assign out_side.temp = s5_temp;
  assign out_side.err  = s5_err | (s5_b4 == '0);
  assign out_side.flag = ~(s5_b7 < bpc_pkg::SIGN_LIMIT);

endmodule

FILE: src/bpc_back.sv
// pressure correction terms and output saturation
module bpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        quo,
  input  bpc_pkg::side_t     in_side,
  output logic               out_vld,
  output bpc_pkg::out_t      out_data
);

  logic [2:0]  vld;
  logic [31:0] p_c, pq_c;

  assign p_c  = in_side.flag ? (quo << 1) : quo;
  assign pq_c = $unsigned($signed(p_c) >>> 8);

  logic [31:0] s1_p, s1_sq, s1_m7;
  logic [15:0] s1_temp;
  logic        s1_err;
  logic [31:0] s2_p, s2_x1m, s2_m7;
  logic [15:0] s2_temp;
  logic        s2_err;

  // final sum and clamp
  logic [31:0] fp_c;
  logic [19:0] pa_c;

  always_comb begin
    fp_c = s2_p + $unsigned($signed($unsigned($signed(s2_x1m) >>> 16)
                                    + $unsigned($signed(s2_m7) >>> 16)
                                    + bpc_pkg::K_OFS) >>> 4);
    if (s2_err || fp_c[31])              pa_c = '0;
    else if (fp_c > {12'b0, bpc_pkg::P_MAX}) pa_c = bpc_pkg::P_MAX;
    else                                 pa_c = fp_c[19:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p    <= p_c;
      s1_sq   <= pq_c * pq_c;
      s1_m7   <= bpc_pkg::K_LIN * p_c;
      s1_temp <= in_side.temp;
      s1_err  <= in_side.err;

      s2_p    <= s1_p;
      s2_x1m  <= s1_sq * bpc_pkg::K_SQ;
      s2_m7   <= s1_m7;
      s2_temp <= s1_temp;
      s2_err  <= s1_err;

      out_data.temperature_tenths <= $signed(s2_temp);
      out_data.pressure_pa        <= pa_c;
      out_data.calc_error         <= s2_err;
    end
  end

  assign out_vld = vld[2];

endmodule

FILE: src/barometric_pressure_compensation.sv
// Barometric pressure compensation, oversampling setting three. One pair of raw
// temperature and pressure words enters per cycle and passes two front stages, a
// 32-stage temperature divider (one quotient bit per stage), five stages of
// coefficient products, a 32-stage pressure divider and three correction and
// clamp stages. The whole pipeline advances together and holds when the output
// register is full and not taken. The user writes calibration groups (reset to
// zero) through the configuration channel only while no item is in flight; the
// block does not enforce it. A zero divisor sets calc_error and zero pressure.
module barometric_pressure_compensation (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpc_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bpc_pkg::out_t       out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  bpc_pkg::cal_t cal;
  logic          adv;

  assign adv       = ~out_valid | out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpc_pkg::CFG_GROUP_A: cal.a <= cfg_data;
        bpc_pkg::CFG_GROUP_B: cal.b <= cfg_data;
        bpc_pkg::CFG_GROUP_C: cal.c <= cfg_data[31:0];
        bpc_pkg::CFG_GROUP_D: cal.d <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // front stages: x1 and temperature division operands
  logic [1:0]  fvld;
  logic [31:0] f1_prod;
  logic [18:0] f1_up, f2_up;
  logic [31:0] x1_c, den_c, num_c;
  logic [31:0] f2_x1, f2_num, f2_den;
  logic        f2_neg;

  always_comb begin
    x1_c  = $unsigned($signed(f1_prod) >>> 15);
    den_c = x1_c + bpc_pkg::sx16(cal.d[31:16]);
    num_c = bpc_pkg::sx16(cal.d[15:0]) << 11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvld <= '0;
    end else if (adv) begin
      fvld <= {fvld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_prod <= ({16'b0, in_data.raw_temperature} - {16'b0, cal.b[47:32]})
                 * {16'b0, cal.b[31:16]};
      f1_up   <= in_data.raw_pressure;
      f2_x1   <= x1_c;
      f2_num  <= num_c[31] ? 32'(-num_c) : num_c;
      f2_den  <= den_c;
      f2_neg  <= num_c[31] ^ den_c[31];
      f2_up   <= f1_up;
    end
  end

  bpc_pkg::side_t t_side;
  logic [31:0]    t_den_abs;

  assign t_den_abs   = f2_den[31] ? 32'(-f2_den) : f2_den;
  assign t_side.x1   = f2_x1;
  assign t_side.up   = f2_up;
  assign t_side.temp = '0;
  assign t_side.err  = (f2_den == '0);
  assign t_side.flag = f2_neg;

  logic           d1_vld, m_vld, d2_vld;
  logic [31:0]    d1_quo, m_num, m_den, d2_quo;
  bpc_pkg::side_t d1_side, m_side, d2_side;

  bpc_div u_tdiv (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(fvld[1]), .num(f2_num), .den(t_den_abs), .in_side(t_side),
    .out_vld(d1_vld), .quo(d1_quo), .out_side(d1_side)
  );

  bpc_mid u_mid (
    .clk(clk), .rst(rst), .en(adv), .cal(cal),
    .in_vld(d1_vld), .quo(d1_quo), .in_side(d1_side),
    .out_vld(m_vld), .num(m_num), .den(m_den), .out_side(m_side)
  );

  bpc_div u_pdiv (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(m_vld), .num(m_num), .den(m_den), .in_side(m_side),
    .out_vld(d2_vld), .quo(d2_quo), .out_side(d2_side)
  );

  bpc_back u_back (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(d2_vld), .quo(d2_quo), .in_side(d2_side),
    .out_vld(out_valid), .out_data(out_data)
  );

endmodule

FILE: src/bpc_checker.sv
module bpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bpc_pkg::out_t       out_data,
  input logic                cfg_ready
);

  // an error result never carries a pressure
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.calc_error |-> out_data.pressure_pa == '0)
    else $error("error result with nonzero pressure");

  // an empty output never holds back input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // input is stalled only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back pressure");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration not ready");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
  .cfg_ready(cfg_ready)
);
